/* rtl/core/bbd_pkg.sv */
package bbd_pkg;

    // default bank size: 64 KiB
    localparam int BANK_SHIFT_DEF = 16;

    // low banks mirrored in 24-bit mode (power of two)
    localparam int LOW_BANK_LIMIT = 256;
    localparam int LOW_BANK_BITS  = $clog2(LOW_BANK_LIMIT);

    localparam logic [31:0] ROM_BASE_RST = 32'h0040_0000;
    localparam logic [31:0] ADDR24_MASK  = 32'h00ff_ffff;

    // green field packing for 565 layout
    localparam logic [31:0] PIX_LOW_MASK_L  = 32'h001f_001f;
    localparam logic [31:0] PIX_NARROW_L    = 32'h7fe0_7fe0;
    localparam logic [31:0] PIX_WIDEN_L     = 32'hffc0_ffc0;
    localparam logic [15:0] PIX_LOW_MASK_W  = 16'h001f;
    localparam logic [15:0] PIX_NARROW_W    = 16'h7fe0;
    localparam logic [15:0] PIX_WIDEN_W     = 16'hffc0;

    typedef enum logic [1:0] {
        REGION_DUMMY = 2'd0,
        REGION_RAM   = 2'd1,
        REGION_ROM   = 2'd2,
        REGION_FRAME = 2'd3
    } t_region;

    typedef enum logic [2:0] {
        CFG_RAM_BASE     = 3'd0,
        CFG_RAM_SIZE     = 3'd1,
        CFG_ROM_BASE     = 3'd2,
        CFG_ROM_SIZE     = 3'd3,
        CFG_FRAME_BASE   = 3'd4,
        CFG_FRAME_SIZE   = 3'd5,
        CFG_FRAME_LAYOUT = 3'd6,
        CFG_ADDR24_MODE  = 3'd7
    } t_cfg_idx;

    localparam logic [2:0] LAYOUT_DIRECT = 3'd0;
    localparam logic [2:0] LAYOUT_555    = 3'd1;
    localparam logic [2:0] LAYOUT_565    = 3'd2;
    localparam logic [2:0] LAYOUT_888    = 3'd3;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;

    typedef struct packed {
        logic [31:0] ram_base;
        logic [31:0] ram_bytes;
        logic [31:0] rom_base;
        logic [31:0] rom_size;
        logic [31:0] frame_base;
        logic [31:0] frame_size;
        logic [2:0]  frame_layout;
        logic        addr24_mode;
    } t_cfg;

endpackage

/* rtl/core/bbd_cfg.sv */
module bbd_cfg
    import bbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_RAM_BASE:     n_cfg.ram_base     = i_cfg_wr_data;
                CFG_RAM_SIZE:     n_cfg.ram_bytes    = i_cfg_wr_data;
                CFG_ROM_BASE:     n_cfg.rom_base     = i_cfg_wr_data;
                CFG_ROM_SIZE:     n_cfg.rom_size     = i_cfg_wr_data;
                CFG_FRAME_BASE:   n_cfg.frame_base   = i_cfg_wr_data;
                CFG_FRAME_SIZE:   n_cfg.frame_size   = i_cfg_wr_data;
                CFG_FRAME_LAYOUT: n_cfg.frame_layout = i_cfg_wr_data[2:0];
                CFG_ADDR24_MODE:  n_cfg.addr24_mode  = i_cfg_wr_data[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ram_base     <= '0;
            r_cfg.ram_bytes    <= '0;
            r_cfg.rom_base     <= ROM_BASE_RST;
            r_cfg.rom_size     <= '0;
            r_cfg.frame_base   <= '0;
            r_cfg.frame_size   <= '0;
            r_cfg.frame_layout <= '0;
            r_cfg.addr24_mode  <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/bbd_decode.sv */
module bbd_decode
    import bbd_pkg::*;
#(
    parameter int BANK_SHIFT = BANK_SHIFT_DEF
)
(
    input  t_cfg        i_cfg,
    input  logic [31:0] i_address,
    output t_region     o_region,
    output logic [31:0] o_region_offset
);

    localparam int BW = 32 - BANK_SHIFT;

    // bank b is covered when the wrapped distance from start is below count
    function automatic logic covers(
        input logic [BW-1:0] bank,
        input logic [BW-1:0] start,
        input logic [BW:0]   count,
        input logic          mode24
    );
        logic [BW-1:0] span;
        begin
            span = bank - start;
            if (mode24 && (start < BW'(LOW_BANK_LIMIT))) begin
                span = {{(BW-LOW_BANK_BITS){1'b0}}, span[LOW_BANK_BITS-1:0]};
            end
            covers = {1'b0, span} < count;
        end
    endfunction

    logic [BW-1:0] bank;
    logic [31:0]   a24;
    logic [31:0]   eff_ram;
    logic [BW:0]   frame_cnt;
    logic          frame_hit;
    logic          rom_hit;
    logic          ram_hit;

    assign bank      = i_address[31:BANK_SHIFT];
    assign a24       = i_cfg.addr24_mode ? (i_address & ADDR24_MASK) : i_address;
    // ram is clamped to the rom base
    assign eff_ram   = (i_cfg.ram_bytes > i_cfg.rom_base) ? i_cfg.rom_base
                                                          : i_cfg.ram_bytes;
    assign frame_cnt = {1'b0, i_cfg.frame_size[31:BANK_SHIFT]} + (BW+1)'(1);

    assign frame_hit = (i_cfg.frame_layout <= LAYOUT_888) &&
                       covers(bank, i_cfg.frame_base[31:BANK_SHIFT], frame_cnt,
                              i_cfg.addr24_mode);
    assign rom_hit   = covers(bank, i_cfg.rom_base[31:BANK_SHIFT],
                              {1'b0, i_cfg.rom_size[31:BANK_SHIFT]}, i_cfg.addr24_mode);
    assign ram_hit   = covers(bank, i_cfg.ram_base[31:BANK_SHIFT],
                              {1'b0, eff_ram[31:BANK_SHIFT]}, i_cfg.addr24_mode);

    always_comb begin
        if (frame_hit) begin
            o_region        = REGION_FRAME;
            o_region_offset = i_address - i_cfg.frame_base;
        end else if (rom_hit) begin
            o_region        = REGION_ROM;
            o_region_offset = a24 - i_cfg.rom_base;
        end else if (ram_hit) begin
            o_region        = REGION_RAM;
            o_region_offset = a24 - i_cfg.ram_base;
        end else begin
            o_region        = REGION_DUMMY;
            o_region_offset = '0;
        end
    end

endmodule

/* rtl/core/bbd_pixconv.sv */
module bbd_pixconv
    import bbd_pkg::*;
(
    input  t_region     i_region,
    input  logic [2:0]  i_frame_layout,
    input  logic        i_kind,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_mem_read_data,
    output logic        o_mem_write_enable,
    output logic [31:0] o_mem_write_value,
    output logic [31:0] o_cpu_read_data
);

    logic [31:0] mask;
    logic [31:0] wd;
    logic [31:0] rd;
    logic [31:0] frame_wr;
    logic [31:0] frame_rd;
    logic [31:0] narrow_l;
    logic [31:0] widen_l;

    always_comb begin
        case (i_access_size)
            SIZE_BYTE: mask = 32'h0000_00ff;
            SIZE_WORD: mask = 32'h0000_ffff;
            default:   mask = 32'hffff_ffff;
        endcase
    end

    assign wd = i_write_data & mask;
    assign rd = i_mem_read_data & mask;

    assign narrow_l = (rd & PIX_LOW_MASK_L) | ((rd >> 1) & PIX_NARROW_L);
    assign widen_l  = (wd & PIX_LOW_MASK_L) | ((wd << 1) & PIX_WIDEN_L);

    always_comb begin
        frame_wr = wd;
        frame_rd = rd;
        if (i_access_size[1]) begin
            // long: halves swapped for both host pixel layouts
            if (i_frame_layout == LAYOUT_555) begin
                frame_wr = {wd[15:0], wd[31:16]};
                frame_rd = {rd[15:0], rd[31:16]};
            end else if (i_frame_layout == LAYOUT_565) begin
                frame_wr = {widen_l[15:0], widen_l[31:16]};
                frame_rd = {narrow_l[15:0], narrow_l[31:16]};
            end
        end else if ((i_access_size == SIZE_WORD) && (i_frame_layout == LAYOUT_565)) begin
            frame_wr = {16'h0000, (wd[15:0] & PIX_LOW_MASK_W) |
                                  ({wd[14:0], 1'b0} & PIX_WIDEN_W)};
            frame_rd = {16'h0000, (rd[15:0] & PIX_LOW_MASK_W) |
                                  ({1'b0, rd[15:1]} & PIX_NARROW_W)};
        end
    end

    always_comb begin
        o_mem_write_enable = 1'b0;
        o_mem_write_value  = '0;
        o_cpu_read_data    = '0;
        case (i_region)
            REGION_FRAME: begin
                if (i_kind) begin
                    o_mem_write_enable = 1'b1;
                    o_mem_write_value  = frame_wr & mask;
                end else begin
                    o_cpu_read_data = frame_rd & mask;
                end
            end
            REGION_ROM: begin
                if (!i_kind) begin
                    o_cpu_read_data = rd;
                end
            end
            REGION_RAM: begin
                if (i_kind) begin
                    o_mem_write_enable = 1'b1;
                    o_mem_write_value  = wd;
                end else begin
                    o_cpu_read_data = rd;
                end
            end
            default: begin
                o_mem_write_enable = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/banked_bus_decoder_with_pixel_convert_unit.sv */
// banked bus decoder with frame-buffer pixel conversion
//
// command channel: an access transfer is taken on a rising edge with start
// high and busy low; busy is never raised, so one access per cycle is taken
// result channel: o_done is high for exactly one cycle with region, offset,
// write enable, write value and cpu read data; the receiver cannot stall
// path: input register, then decode and convert into the result register
// throughput: one access per cycle, fully overlapped
// configuration: plain write port, register index i_cfg_addr, applied at
// the edge where i_cfg_wr_en is high; write only while no access is in flight
// reset (synchronous, active low): configuration returns to its defaults
// (rom base at 4 MiB, everything else zero) and both stage valids clear
module banked_bus_decoder_with_pixel_convert_unit
    import bbd_pkg::*;
#(
    parameter int BANK_SHIFT = BANK_SHIFT_DEF
)
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wr_data,
    // access command
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [1:0]  i_access_size,
    input  logic [31:0] i_address,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_mem_read_data,
    // result
    output logic        o_done,
    output logic [1:0]  o_region,
    output logic [31:0] o_region_offset,
    output logic        o_mem_write_enable,
    output logic [31:0] o_mem_write_value,
    output logic [31:0] o_cpu_read_data
);

    t_cfg        cfg;

    // input stage
    logic        r_s1_vld;
    logic        r_kind;
    logic [1:0]  r_access_size;
    logic [31:0] r_address;
    logic [31:0] r_write_data;
    logic [31:0] r_mem_read_data;

    // decode and convert results
    t_region     dec_region;
    logic [31:0] dec_offset;
    logic        cv_wen;
    logic [31:0] cv_wval;
    logic [31:0] cv_rval;

    // result stage
    logic        r_done;
    logic [1:0]  r_region;
    logic [31:0] r_region_offset;
    logic        r_wen;
    logic [31:0] r_wval;
    logic [31:0] r_rval;

    logic        accept;

    // the pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    bbd_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (cfg)
    );

    // capture the access transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind          <= i_kind;
            r_access_size   <= i_access_size;
            r_address       <= i_address;
            r_write_data    <= i_write_data;
            r_mem_read_data <= i_mem_read_data;
        end
    end

    // bank lookup with frame > rom > ram > dummy priority
    bbd_decode #(
        .BANK_SHIFT (BANK_SHIFT)
    ) u_decode (
        .i_cfg           (cfg),
        .i_address       (r_address),
        .o_region        (dec_region),
        .o_region_offset (dec_offset)
    );

    // size masking, write filtering and frame pixel packing
    bbd_pixconv u_pixconv (
        .i_region           (dec_region),
        .i_frame_layout     (cfg.frame_layout),
        .i_kind             (r_kind),
        .i_access_size      (r_access_size),
        .i_write_data       (r_write_data),
        .i_mem_read_data    (r_mem_read_data),
        .o_mem_write_enable (cv_wen),
        .o_mem_write_value  (cv_wval),
        .o_cpu_read_data    (cv_rval)
    );

    // result register, shown for exactly one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_region        <= dec_region;
            r_region_offset <= dec_offset;
            r_wen           <= cv_wen;
            r_wval          <= cv_wval;
            r_rval          <= cv_rval;
        end
    end

    assign o_done             = r_done;
    assign o_region           = r_region;
    assign o_region_offset    = r_region_offset;
    assign o_mem_write_enable = r_wen;
    assign o_mem_write_value  = r_wval;
    assign o_cpu_read_data    = r_rval;

endmodule
